FILE: rtl/gksm_pkg.sv
`timescale 1ns / 1ps

package gksm_pkg;

    // fixed field widths
    localparam int NODE_W     = 6;
    localparam int DIST_IN_W  = 16;
    localparam int COST_W     = 32;
    localparam int SRV_SEL_W  = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int START_REGS = 4;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    // operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_SERVE   = 2'd2;

    typedef struct packed {
        logic [1:0]           operation;
        logic [NODE_W-1:0]    node_a;
        logic [NODE_W-1:0]    node_b;
        logic [DIST_IN_W-1:0] distance_value;
    } item_t;

    typedef struct packed {
        logic                 hit;
        logic [SRV_SEL_W-1:0] moved_server;
        logic [DIST_IN_W-1:0] step_cost;
        logic [COST_W-1:0]    total_cost;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_LAST,
        ST_MOVE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic                 latch;
        logic                 eval;
        logic                 rd_en;
        logic [SRV_SEL_W-1:0] rd_sel;
        logic                 cmp_en;
        logic [SRV_SEL_W-1:0] cmp_sel;
        logic                 move;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_needed;
    } status_t;

endpackage

FILE: rtl/gksm_ctrl.sv
`timescale 1ns / 1ps

module gksm_ctrl #(
    parameter int SERVER_COUNT = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  gksm_pkg::status_t status,
    output gksm_pkg::cmd_t    cmd
);
    import gksm_pkg::*;

    localparam int SW = $clog2(SERVER_COUNT);
    localparam logic [SW-1:0] LAST_SRV = SW'(SERVER_COUNT - 1);

    state_t        state_reg, state_next;
    logic [SW-1:0] cnt_reg, cnt_next;

    // state and read counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cnt_next = '0;
                if (status.scan_needed)
                    state_next = ST_SCAN;
                else
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_SRV)
                    state_next = ST_LAST;
            end
            ST_LAST:
                state_next = ST_MOVE;
            ST_MOVE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                cmd.latch = start;
            end
            ST_EVAL:
                cmd.eval = 1'b1;
            ST_SCAN:
            begin
                // issue read for this server, compare the previous one
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = SRV_SEL_W'(cnt_reg);
                cmd.cmp_en  = (cnt_reg != '0);
                cmd.cmp_sel = SRV_SEL_W'(cnt_reg - 1'b1);
            end
            ST_LAST:
            begin
                cmd.cmp_en  = 1'b1;
                cmd.cmp_sel = SRV_SEL_W'(LAST_SRV);
            end
            ST_MOVE:
                cmd.move = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

endmodule

FILE: rtl/gksm_datapath.sv
`timescale 1ns / 1ps

module gksm_datapath #(
    parameter int NODE_COUNT    = 64,
    parameter int SERVER_COUNT  = 4,
    parameter int DISTANCE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gksm_pkg::item_t                     item,
    input  logic                                cfg_we,
    input  logic [gksm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gksm_pkg::NODE_W-1:0]         cfg_wdata,
    input  gksm_pkg::cmd_t                      cmd,
    output gksm_pkg::status_t                   status,
    output gksm_pkg::result_t                   result,
    output logic                                done
);
    import gksm_pkg::*;

    localparam int IDXW      = $clog2(NODE_COUNT);
    localparam int AW        = 2 * IDXW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int SW        = $clog2(SERVER_COUNT);
    localparam logic [8:0] NODE_LIMIT = 9'(NODE_COUNT);
    localparam logic [DISTANCE_BITS-1:0] DIST_MAX = '1;

    logic [DISTANCE_BITS-1:0] mem [0:MEM_DEPTH-1];

    item_t                    item_reg;
    logic [NODE_W-1:0]        start_reg [START_REGS];
    logic [NODE_W-1:0]        pos_reg [SERVER_COUNT];
    logic [COST_W-1:0]        cost_reg, cost_next;
    logic                     done_reg, done_next;
    result_t                  result_reg, result_next;
    logic [DISTANCE_BITS-1:0] rd_data_reg;
    logic                     off_reg;
    logic [DISTANCE_BITS-1:0] best_reg;
    logic [SW-1:0]            besti_reg;

    logic                     node_a_ok, node_b_ok, any_hit, serve_ok;
    logic [AW-1:0]            wr_addr, rd_addr;
    logic [NODE_W-1:0]        rd_pos;
    logic [DISTANCE_BITS-1:0] cmp_dist;
    logic [COST_W:0]          cost_sum;

    // decode of the latched item
    assign node_a_ok = (9'(item_reg.node_a) < NODE_LIMIT);
    assign node_b_ok = (9'(item_reg.node_b) < NODE_LIMIT);
    assign serve_ok  = (item_reg.operation == OP_SERVE) && node_a_ok;

    always_comb
    begin
        any_hit = 1'b0;
        for (int s = 0; s < SERVER_COUNT; s++)
            if (pos_reg[s] == item_reg.node_a)
                any_hit = 1'b1;
    end

    assign status.scan_needed = serve_ok && !any_hit;

    // table addresses
    assign wr_addr = {IDXW'(item_reg.node_a), IDXW'(item_reg.node_b)};
    assign rd_pos  = pos_reg[cmd.rd_sel[SW-1:0]];
    assign rd_addr = {IDXW'(item_reg.node_a), IDXW'(rd_pos)};

    // distance table, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.eval && (item_reg.operation == OP_LOAD) && node_a_ok && node_b_ok)
            mem[wr_addr] <= DISTANCE_BITS'(item_reg.distance_value);
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            off_reg     <= (9'(rd_pos) >= NODE_LIMIT);
        end
    end

    // a server off the table is seen at the largest distance
    assign cmp_dist = off_reg ? DIST_MAX : rd_data_reg;

    // item latch and running minimum
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            item_reg <= item;
        if (cmd.cmp_en && ((cmd.cmp_sel == '0) || (cmp_dist < best_reg)))
        begin
            best_reg  <= cmp_dist;
            besti_reg <= cmd.cmp_sel[SW-1:0];
        end
        result_reg <= result_next;
    end

    assign cost_sum = {1'b0, cost_reg} + (COST_W + 1)'(best_reg);

    // cost and result update
    always_comb
    begin
        cost_next   = cost_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (cmd.eval && !status.scan_needed)
        begin
            if (item_reg.operation == OP_RESTART)
                cost_next = '0;
            done_next                = 1'b1;
            result_next.hit          = serve_ok && any_hit;
            result_next.moved_server = '0;
            result_next.step_cost    = '0;
            result_next.total_cost   = cost_next;
        end
        else if (cmd.move)
        begin
            cost_next = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
            done_next                = 1'b1;
            result_next.hit          = 1'b0;
            result_next.moved_server = SRV_SEL_W'(besti_reg);
            result_next.step_cost    = DIST_IN_W'(best_reg);
            result_next.total_cost   = cost_next;
        end
    end

    // control state: start registers, positions, cost, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < START_REGS; r++)
                start_reg[r] <= NODE_W'(r);
            for (int s = 0; s < SERVER_COUNT; s++)
                pos_reg[s] <= NODE_W'(s);
            cost_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                start_reg[cfg_addr] <= cfg_wdata;
            if (cmd.eval && (item_reg.operation == OP_RESTART))
            begin
                for (int s = 0; s < SERVER_COUNT; s++)
                    pos_reg[s] <= start_reg[s];
            end
            else if (cmd.move)
                pos_reg[besti_reg] <= item_reg.node_a;
            cost_reg <= cost_next;
            done_reg <= done_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

FILE: rtl/greedy_k_server_mover_top.sv
`timescale 1ns / 1ps
// greedy k-server mover: one result per item, shown for one cycle with done
// a request that misses is accepted, evaluated and then scanned:
// one table read per server through the single read port, then compare and move
// loads, restarts, hits and out-of-range requests skip the scan and finish after evaluation
// reset: start registers 0,1,2,3, servers at those nodes, cost zero; the
// distance table is not cleared; results cannot be stalled by the receiver
module greedy_k_server_mover_top #(
    parameter int NODE_COUNT    = 64,
    parameter int SERVER_COUNT  = 4,
    parameter int DISTANCE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  gksm_pkg::item_t                 item,
    output logic                            done,
    output gksm_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [gksm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gksm_pkg::NODE_W-1:0]     cfg_wdata
);
    import gksm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    gksm_ctrl #(
        .SERVER_COUNT (SERVER_COUNT)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // table, positions and cost
    gksm_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .SERVER_COUNT  (SERVER_COUNT),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .done      (done)
    );

`ifndef SYNTHESIS
    // a result only appears once the sequencer is back at idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // an accepted item makes the block busy with no stale strobe
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy && !done))
        else $error("accept did not start work");

    // latch, eval, read and move commands do not overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch, cmd.eval, cmd.rd_en, cmd.move}))
        else $error("overlapping commands");

    // a hit never reports a move or a cost
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit) |-> (result.step_cost == '0 && result.moved_server == '0))
        else $error("hit with move or cost");
`endif

endmodule
